FILE: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge, off during reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on the rising edge, off during reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mmss_pkg.sv
// shared types and constants of the min/max/sum stack
package mmss_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int VAL_W     = 32;
	localparam int SUM_W     = 40;
	localparam int CNT_OUT_W = 9;
	localparam int TDATA_W   = 216;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic start_div;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

FILE: hdl/mmss_div.sv
// iterative restoring divider: signed sum over unsigned count, one bit a cycle
module mmss_div #(
	parameter int CW = 9
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [mmss_pkg::SUM_W-1:0]  dividend,
	input  logic [CW-1:0]                      divisor,
	output logic                               done,
	output logic signed [mmss_pkg::VAL_W-1:0]  quotient
);
	import mmss_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [SUM_W-1:0]     q_q;
	logic [CW-1:0]        rem_q;
	logic [CW-1:0]        div_q;
	logic                 neg_q;

	logic [SUM_W-1:0] mag;
	logic [CW:0]      trial;
	logic [CW:0]      diff;
	logic             ge;
	logic [SUM_W-1:0] q_signed;

	assign mag   = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
	assign trial = {rem_q, q_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(SUM_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - DIV_CNT_W'(1);
				done_q <= (cnt_q == DIV_CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= mag;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (cnt_q != '0) begin
			q_q   <= {q_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	assign q_signed = neg_q ? (SUM_W'(0) - q_q) : q_q;
	assign quotient = q_signed[VAL_W-1:0];
	assign done     = done_q;

endmodule

FILE: hdl/mmss_ctrl.sv
// controller state machine of the min/max/sum stack
module mmss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output mmss_pkg::cmd_t    cmd,
	input  mmss_pkg::status_t stat
);
	import mmss_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_START;
			end
			ST_START: begin
				cmd.start_div = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait until the output register can take the beat
				if (stat.out_free) begin
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/mmss_datapath.sv
// datapath: the three stores, counts, running sum, divider and output register
module mmss_datapath #(
	parameter int DEPTH = mmss_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [mmss_pkg::VAL_W-1:0]          s_axis_tdata,
	input  logic                                s_axis_tuser,
	input  mmss_pkg::cmd_t                      cmd,
	output mmss_pkg::status_t                   stat,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mmss_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic [1:0]                          m_axis_tuser
);
	import mmss_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                    op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]           main_cnt_q, min_cnt_q, max_cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	stat_code_t              status_q;

	logic [VAL_W-1:0] main_mem [DEPTH];
	logic [VAL_W-1:0] min_mem  [DEPTH];
	logic [VAL_W-1:0] max_mem  [DEPTH];
	logic signed [VAL_W-1:0] main_rd_q, min_rd_q, max_rd_q;

	logic [CW-1:0] main_m1, min_m1, max_m1;
	logic          full, empty_in;
	logic          push_ok, pop_ok;
	logic          min_push, max_push, min_pop, max_pop;

	logic                    div_done;
	logic signed [VAL_W-1:0] quot;

	logic                    empty_o, full_o;
	logic signed [VAL_W-1:0] top_o, mn_o, mx_o, avg_o, med_o;
	logic signed [VAL_W:0]   pair, pair_adj;
	logic [CW+CNT_OUT_W-1:0] cnt_wide;
	logic [TDATA_W-1:0]      tdata_d;

	logic                    out_valid_q;
	logic [TDATA_W-1:0]      out_data_q;
	logic [1:0]              out_user_q;

	assign main_m1 = main_cnt_q - CW'(1);
	assign min_m1  = min_cnt_q - CW'(1);
	assign max_m1  = max_cnt_q - CW'(1);

	assign full     = (main_cnt_q == CW'(DEPTH));
	assign empty_in = (main_cnt_q == '0);
	assign push_ok  = (op_q == OP_PUSH) && !full;
	assign pop_ok   = (op_q == OP_POP) && !empty_in;

	// an auxiliary stack takes a value that ties or beats its top
	assign min_push = push_ok && ((min_cnt_q == '0) || (val_q <= min_rd_q))
		&& (min_cnt_q != CW'(DEPTH));
	assign max_push = push_ok && ((max_cnt_q == '0) || (val_q >= max_rd_q))
		&& (max_cnt_q != CW'(DEPTH));
	assign min_pop  = pop_ok && (min_cnt_q != '0) && (min_rd_q == main_rd_q);
	assign max_pop  = pop_ok && (max_cnt_q != '0) && (max_rd_q == main_rd_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_axis_tuser;
			val_q <= s_axis_tdata;
		end
		if (cmd.exec) begin
			priority if ((op_q == OP_PUSH) && full) begin
				status_q <= STAT_FULL;
			end else if ((op_q == OP_POP) && empty_in) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_DONE;
			end
		end
	end

	// stores: top of each stack read every cycle, registered
	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			main_mem[main_cnt_q[AW-1:0]] <= val_q;
		end
		main_rd_q <= main_mem[main_m1[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && min_push) begin
			min_mem[min_cnt_q[AW-1:0]] <= val_q;
		end
		min_rd_q <= min_mem[min_m1[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && max_push) begin
			max_mem[max_cnt_q[AW-1:0]] <= val_q;
		end
		max_rd_q <= max_mem[max_m1[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_cnt_q <= '0;
			min_cnt_q  <= '0;
			max_cnt_q  <= '0;
			sum_q      <= '0;
		end else if (cmd.exec) begin
			if (push_ok) begin
				main_cnt_q <= main_cnt_q + CW'(1);
				sum_q      <= sum_q + SUM_W'(val_q);
			end else if (pop_ok) begin
				main_cnt_q <= main_m1;
				sum_q      <= sum_q - SUM_W'(main_rd_q);
			end
			if (min_push) begin
				min_cnt_q <= min_cnt_q + CW'(1);
			end else if (min_pop) begin
				min_cnt_q <= min_m1;
			end
			if (max_push) begin
				max_cnt_q <= max_cnt_q + CW'(1);
			end else if (max_pop) begin
				max_cnt_q <= max_m1;
			end
		end
	end

	mmss_div #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (sum_q),
		.divisor  (main_cnt_q),
		.done     (div_done),
		.quotient (quot)
	);

	// result fields from the state after the operation
	assign empty_o = (main_cnt_q == '0);
	assign full_o  = (main_cnt_q == CW'(DEPTH));
	assign top_o   = empty_o ? -VAL_W'(1) : main_rd_q;
	assign mn_o    = (!empty_o && (min_cnt_q != '0)) ? min_rd_q : -VAL_W'(1);
	assign mx_o    = (!empty_o && (max_cnt_q != '0)) ? max_rd_q : -VAL_W'(1);
	assign avg_o   = empty_o ? '0 : quot;

	// wide add, then halve rounding toward zero
	assign pair     = {mn_o[VAL_W-1], mn_o} + {mx_o[VAL_W-1], mx_o};
	assign pair_adj = pair + {{VAL_W{1'b0}}, pair[VAL_W]};
	assign med_o    = empty_o ? '0 : pair_adj[VAL_W:1];

	assign cnt_wide = (CW + CNT_OUT_W)'(main_cnt_q);

	assign tdata_d = {5'b0, full_o, empty_o, cnt_wide[CNT_OUT_W-1:0],
		med_o, avg_o, sum_q, mx_o, mn_o, top_o};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			out_data_q <= tdata_d;
			out_user_q <= status_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || m_axis_tready;

endmodule

FILE: hdl/min_max_sum_stack.sv
// top level of the min/max/sum stack
// Usage:
//   Slave channel s_axis_*: one beat per operation. tuser bit 0 is the opcode
//   (0 push, 1 pop); tdata holds the signed 32-bit value to push.
//   Master channel m_axis_*: one beat per operation. tuser carries the status
//   code (0 done, 1 push refused when full, 2 pop ignored when empty); tdata
//   holds the stack state after the operation.
//   One operation is in work at a time. s_axis_tready is high only while the
//   controller is idle; between two accepts the controller passes through the
//   store update, the divider load, the 40-step bit-serial divider that forms
//   the average and its done flag, the hand-over into the output register and
//   the idle state that takes a beat.
//   The result beat appears on m_axis_tvalid once the done flag has moved the
//   controller to the hand-over and the output register has taken the result.
//   The output register holds the result while the receiver stalls; the next
//   operation is accepted and computed meanwhile and waits only at its own
//   hand-over into the output register.
//   Reset (arst_n low) empties the stack and clears the sum and the counts;
//   store contents are kept undefined and are never read below an empty count.
`include "assert_macros.svh"

module min_max_sum_stack #(
	parameter int DEPTH = mmss_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [31:0] value
	input  logic [mmss_pkg::VAL_W-1:0]   s_axis_tdata,
	// [0] opcode
	input  logic                         s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [31:0] top_value, [63:32] min_value, [95:64] max_value, [135:96] running_sum,
	// [167:136] average_value, [199:168] median_value, [208:200] entry_count,
	// [209] is_empty, [210] is_full, [215:211] zero
	output logic [mmss_pkg::TDATA_W-1:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0]                   m_axis_tuser
);
	import mmss_pkg::*;

	cmd_t    cmd;
	status_t stat;

	mmss_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cmd           (cmd),
		.stat          (stat)
	);

	mmss_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	`CHK_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after an accepted beat")
	`CHK_IMPLY(a_capture_free, clk, arst_n, cmd.capture, stat.out_free, "result captured over a pending beat")
	`CHK_IMPLY(a_full_flag, clk, arst_n, m_axis_tvalid && (m_axis_tuser == STAT_FULL), m_axis_tdata[210], "refused push without full flag")
	`CHK_IMPLY(a_empty_flag, clk, arst_n, m_axis_tvalid && (m_axis_tuser == STAT_EMPTY), m_axis_tdata[209], "ignored pop without empty flag")

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the min/max/sum stack: directed table, random phases, a fill to full
`timescale 1ns / 1ps

module tb_top;
	import mmss_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 60;

	typedef struct packed {
		stat_code_t  status;
		logic [31:0] top_value;
		logic [31:0] min_value;
		logic [31:0] max_value;
		logic [39:0] running_sum;
		logic [31:0] average_value;
		logic [31:0] median_value;
		logic [8:0]  entry_count;
		logic        is_empty;
		logic        is_full;
	} stack_res_t;

	typedef struct {
		logic        op;
		logic [31:0] value;
		bit          typed;
		stack_res_t  res;
	} dir_row_t;

	localparam stack_res_t RES_NONE = '0;
	// pop on an empty stack
	localparam stack_res_t RES_POP_IGNORED = '{STAT_EMPTY, 32'hFFFFFFFF, 32'hFFFFFFFF,
		32'hFFFFFFFF, 40'h0, 32'h0, 32'h0, 9'd0, 1'b1, 1'b0};
	// last entry popped
	localparam stack_res_t RES_DRAINED = '{STAT_DONE, 32'hFFFFFFFF, 32'hFFFFFFFF,
		32'hFFFFFFFF, 40'h0, 32'h0, 32'h0, 9'd0, 1'b1, 1'b0};
	// single largest word on an empty stack
	localparam stack_res_t RES_ONE_MAX = '{STAT_DONE, 32'h7FFFFFFF, 32'h7FFFFFFF,
		32'h7FFFFFFF, 40'h007FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 9'd1, 1'b0, 1'b0};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [215:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int fail_cnt = 0;
	int quiet_cycles = 0;

	// predictor state
	logic [31:0] stk_mem [DEPTH];
	logic [31:0] min_hist [DEPTH];
	logic [31:0] max_hist [DEPTH];
	int          stk_cnt = 0;
	int          min_cnt = 0;
	int          max_cnt = 0;
	logic [39:0] stk_sum = '0;

	stack_res_t pending_results [$];

	dir_row_t dir_tab [24] = '{
		'{OP_POP,  32'h00000000, 1'b1, RES_POP_IGNORED},
		'{OP_PUSH, 32'h7FFFFFFF, 1'b1, RES_ONE_MAX},
		'{OP_PUSH, 32'h80000000, 1'b0, RES_NONE},
		'{OP_PUSH, 32'h00000000, 1'b0, RES_NONE},
		'{OP_PUSH, 32'h80000000, 1'b0, RES_NONE},
		'{OP_PUSH, 32'h7FFFFFFF, 1'b0, RES_NONE},
		'{OP_PUSH, 32'hFFFFFFFF, 1'b0, RES_NONE},
		'{OP_PUSH, 32'h00000005, 1'b0, RES_NONE},
		'{OP_PUSH, 32'h00000005, 1'b0, RES_NONE},
		'{OP_POP,  32'hFFFFFFFF, 1'b0, RES_NONE},
		'{OP_POP,  32'h12345678, 1'b0, RES_NONE},
		'{OP_POP,  32'h80000000, 1'b0, RES_NONE},
		'{OP_POP,  32'h7FFFFFFF, 1'b0, RES_NONE},
		'{OP_POP,  32'hA5A5A5A5, 1'b0, RES_NONE},
		'{OP_POP,  32'h5A5A5A5A, 1'b0, RES_NONE},
		'{OP_POP,  32'h00000001, 1'b0, RES_NONE},
		'{OP_POP,  32'hFFFFFFFE, 1'b1, RES_DRAINED},
		'{OP_POP,  32'hFFFFFFFF, 1'b1, RES_POP_IGNORED},
		'{OP_PUSH, 32'hFFFFFFF9, 1'b0, RES_NONE},
		'{OP_PUSH, 32'h00000002, 1'b0, RES_NONE},
		'{OP_PUSH, 32'hFFFFFFFE, 1'b0, RES_NONE},
		'{OP_POP,  32'h00000000, 1'b0, RES_NONE},
		'{OP_POP,  32'h00000000, 1'b0, RES_NONE},
		'{OP_POP,  32'h00000000, 1'b1, RES_DRAINED}
	};

	min_max_sum_stack DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic stack_res_t stack_predict(input logic op, input logic [31:0] word);
		stack_res_t  r;
		longint      sval;
		longint      mn;
		longint      mx;
		longint      avg;
		longint      med;
		logic [31:0] leaving;
		r = '0;
		r.status = STAT_DONE;
		sval = longint'($signed(word));
		if (op == OP_PUSH) begin
			if (stk_cnt >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				stk_mem[stk_cnt] = word;
				stk_cnt++;
				stk_sum = stk_sum + sval[39:0];
				if (min_cnt == 0 || sval <= longint'($signed(min_hist[min_cnt-1]))) begin
					if (min_cnt < DEPTH) begin
						min_hist[min_cnt] = word;
						min_cnt++;
					end
				end
				if (max_cnt == 0 || sval >= longint'($signed(max_hist[max_cnt-1]))) begin
					if (max_cnt < DEPTH) begin
						max_hist[max_cnt] = word;
						max_cnt++;
					end
				end
			end
		end else begin
			if (stk_cnt == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				leaving = stk_mem[stk_cnt-1];
				if (min_cnt > 0 && min_hist[min_cnt-1] == leaving)
					min_cnt--;
				if (max_cnt > 0 && max_hist[max_cnt-1] == leaving)
					max_cnt--;
				stk_cnt--;
				sval = longint'($signed(leaving));
				stk_sum = stk_sum - sval[39:0];
			end
		end
		mn = -1;
		mx = -1;
		avg = 0;
		med = 0;
		if (stk_cnt == 0) begin
			r.top_value = 32'hFFFFFFFF;
		end else begin
			r.top_value = stk_mem[stk_cnt-1];
			if (min_cnt > 0)
				mn = longint'($signed(min_hist[min_cnt-1]));
			if (max_cnt > 0)
				mx = longint'($signed(max_hist[max_cnt-1]));
			// both divisions truncate toward zero
			avg = longint'($signed(stk_sum)) / longint'(stk_cnt);
			med = (mn + mx) / 2;
		end
		r.min_value     = mn[31:0];
		r.max_value     = mx[31:0];
		r.running_sum   = stk_sum;
		r.average_value = avg[31:0];
		r.median_value  = med[31:0];
		r.entry_count   = stk_cnt[8:0];
		r.is_empty      = (stk_cnt == 0);
		r.is_full       = (stk_cnt == DEPTH);
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'(int'($urandom_range(16)) - 8);
			2: begin
				case ($urandom_range(3))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'h00000000;
					default: return 32'hFFFFFFFF;
				endcase
			end
			default: begin
				// repeat the top so equal values reach the min and max histories
				if (stk_cnt > 0)
					return stk_mem[stk_cnt-1];
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_op(input logic op, input logic [31:0] word, input bit typed,
		input stack_res_t typed_res, output stat_code_t st);
		stack_res_t r;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(90, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		r = stack_predict(op, word);
		st = r.status;
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic run_random(input int n);
		int         done_cnt;
		int         push_pct;
		bit         deep;
		logic       op;
		stat_code_t st;
		done_cnt = 0;
		while (done_cnt < n) begin
			deep = ($urandom_range(3) == 0);
			repeat ($urandom_range(24, 1)) begin
				if (deep)
					push_pct = 85;
				else if (stk_cnt < 4)
					push_pct = 75;
				else if (stk_cnt > 200)
					push_pct = 30;
				else
					push_pct = 55;
				op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
				send_op(op, pick_value(), 1'b0, RES_NONE, st);
				if (st == STAT_DONE)
					done_cnt++;
			end
		end
	endtask

	task automatic fill_stack();
		stat_code_t st;
		while (stk_cnt < DEPTH)
			send_op(OP_PUSH, pick_value(), 1'b0, RES_NONE, st);
		// refused pushes on the full stack
		repeat (2) send_op(OP_PUSH, $urandom, 1'b0, RES_NONE, st);
	endtask

	task automatic check_field(input string name, input logic [39:0] want,
		input logic [39:0] got);
		if (want !== got) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// result side ready, with one long hold-off on request
	initial begin : sink_ready
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		stack_res_t want;
		stack_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status        = stat_code_t'(m_axis_tuser);
			got.top_value     = m_axis_tdata[31:0];
			got.min_value     = m_axis_tdata[63:32];
			got.max_value     = m_axis_tdata[95:64];
			got.running_sum   = m_axis_tdata[135:96];
			got.average_value = m_axis_tdata[167:136];
			got.median_value  = m_axis_tdata[199:168];
			got.entry_count   = m_axis_tdata[208:200];
			got.is_empty      = m_axis_tdata[209];
			got.is_full       = m_axis_tdata[210];
			if (pending_results.size() == 0) begin
				fail_cnt++;
				$display("%0t: result beat with nothing expected, actual tuser %h tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 40'(want.status), 40'(got.status));
				check_field("top_value", 40'(want.top_value), 40'(got.top_value));
				check_field("min_value", 40'(want.min_value), 40'(got.min_value));
				check_field("max_value", 40'(want.max_value), 40'(got.max_value));
				check_field("running_sum", want.running_sum, got.running_sum);
				check_field("average_value", 40'(want.average_value), 40'(got.average_value));
				check_field("median_value", 40'(want.median_value), 40'(got.median_value));
				check_field("entry_count", 40'(want.entry_count), 40'(got.entry_count));
				check_field("is_empty", 40'(want.is_empty), 40'(got.is_empty));
				check_field("is_full", 40'(want.is_full), 40'(got.is_full));
				if (m_axis_tdata[215:211] !== 5'd0)
					check_field("tdata pad", 40'd0, 40'(m_axis_tdata[215:211]));
			end
		end
	end

	// no beat on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stat_code_t st;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (dir_tab[i])
			send_op(dir_tab[i].op, dir_tab[i].value, dir_tab[i].typed, dir_tab[i].res, st);
		// sink holds off while items keep coming, so the input backs up
		hold_req = 1'b1;
		run_random(30);
		fill_stack();
		wait_drained();

		send_idle_pct  = 76;
		recv_stall_pct = 0;
		run_random(30);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 76;
		run_random(30);
		wait_drained();

		send_idle_pct  = 36;
		recv_stall_pct = 36;
		run_random(30);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
